@@ rtl/ptrq_pkg.sv @@
// ptrq_pkg: shared types and constants for the priority task ready queue
// no dependencies; imported by the interfaces and all ptrq modules
`timescale 1ns / 1ps
`default_nettype none

package ptrq_pkg;

	localparam int MAX_TASKS = 32;
	localparam int PRIO_BITS = 8;
	localparam int SLOT_W    = 5;
	localparam int CNT_W     = 6;

	localparam logic [CNT_W-1:0] NONE_SLOT = CNT_W'(MAX_TASKS);
	localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(MAX_TASKS);

	typedef enum logic [1:0] {
		REQ_ACTIVATE  = 2'd0,
		REQ_TERMINATE = 2'd1,
		REQ_DISPATCH  = 2'd2
	} req_code_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_FREE  = 2'd1,
		ST_NO_READY = 2'd2,
		ST_ALL_DONE = 2'd3
	} status_t;

	// ready row operations
	typedef enum logic [2:0] {
		RQ_NOP,
		RQ_INSERT,
		RQ_ROTATE,
		RQ_REMOVE,
		RQ_PACK
	} rq_op_t;

	// free stack operations
	typedef enum logic [1:0] {
		FL_NOP,
		FL_POP,
		FL_PUSH
	} fl_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_PACK,
		S_DISP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                 valid;
		logic [SLOT_W-1:0]    slot;
		logic [PRIO_BITS-1:0] prio;
	} rq_entry_t;

	typedef struct packed {
		rq_op_t               op;
		logic [SLOT_W-1:0]    slot;
		logic [PRIO_BITS-1:0] prio;
	} rq_cmd_t;

	typedef struct packed {
		fl_op_t            op;
		logic [SLOT_W-1:0] slot;
	} fl_cmd_t;

endpackage

`default_nettype wire

@@ rtl/ptrq_ifs.sv @@
// ptrq request and result channel interfaces (valid/ready handshake)
// depends on ptrq_pkg
`timescale 1ns / 1ps
`default_nettype none

interface ptrq_req_if;
	import ptrq_pkg::*;
	logic       valid;
	logic       ready;
	logic [1:0] req_type;
	logic [7:0] priority_req;

	modport source (output valid, output req_type, output priority_req, input ready);
	modport sink (input valid, input req_type, input priority_req, output ready);
endinterface

interface ptrq_rsp_if;
	import ptrq_pkg::*;
	logic              valid;
	logic              ready;
	logic [1:0]        status;
	logic [SLOT_W-1:0] slot;
	logic [CNT_W-1:0]  running_task;
	logic              switched;
	logic              first_run;
	logic [CNT_W-1:0]  task_count;

	modport source (output valid, output status, output slot, output running_task,
		output switched, output first_run, output task_count, input ready);
	modport sink (input valid, input status, input slot, input running_task,
		input switched, input first_run, input task_count, output ready);
endinterface

`default_nettype wire

@@ rtl/ptrq_ready_cell.sv @@
// ptrq_ready_cell: one position of the priority-sorted ready row
// depends on ptrq_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptrq_ready_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  ptrq_pkg::rq_cmd_t   cmd,
	input  ptrq_pkg::rq_entry_t left_ent,
	input  wire                 left_ge,
	input  ptrq_pkg::rq_entry_t right_ent,
	input  wire                 right_ge,
	output ptrq_pkg::rq_entry_t ent,
	output logic                ge
);
	import ptrq_pkg::*;

	rq_entry_t ent_q;
	rq_entry_t ent_d;
	rq_entry_t key_ent;

	assign ent = ent_q;
	// this entry ranks at or above the key priority
	assign ge = ent_q.valid && (ent_q.prio >= cmd.prio);

	always_comb begin
		key_ent = '{valid: 1'b1, slot: cmd.slot, prio: cmd.prio};
		ent_d   = ent_q;
		case (cmd.op)
			RQ_INSERT: begin
				if (!left_ge) begin
					ent_d = left_ent;
				end else if (!ge) begin
					ent_d = key_ent;
				end
			end
			RQ_ROTATE: begin
				if (right_ge) begin
					ent_d = right_ent;
				end else if (ge) begin
					ent_d = key_ent;
				end
			end
			RQ_REMOVE: begin
				if (ent_q.valid && ent_q.slot == cmd.slot) begin
					ent_d.valid = 1'b0;
				end
			end
			RQ_PACK: begin
				// hole walks one cell right per cycle
				if (!ent_q.valid) begin
					ent_d = right_ent;
				end else if (!left_ent.valid) begin
					ent_d.valid = 1'b0;
				end
			end
			default: ent_d = ent_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q <= '0;
		end else begin
			ent_q <= ent_d;
		end
	end

endmodule

`default_nettype wire

@@ rtl/ptrq_free_cell.sv @@
// ptrq_free_cell: one position of the free-slot stack row
// depends on ptrq_pkg
`timescale 1ns / 1ps
`default_nettype none

module ptrq_free_cell #(
	parameter int INDEX = 0
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  ptrq_pkg::fl_cmd_t           cmd,
	input  wire [ptrq_pkg::SLOT_W-1:0]  left_slot,
	input  wire [ptrq_pkg::SLOT_W-1:0]  right_slot,
	output logic [ptrq_pkg::SLOT_W-1:0] slot
);
	import ptrq_pkg::*;

	logic [SLOT_W-1:0] slot_q;

	assign slot = slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= SLOT_W'(INDEX);
		end else begin
			case (cmd.op)
				FL_POP:  slot_q <= right_slot;
				FL_PUSH: slot_q <= left_slot;
				default: slot_q <= slot_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ rtl/ptrq_ctrl.sv @@
// ptrq_ctrl: request sequencer, running/count/has-run state and result register
// depends on ptrq_pkg and ptrq_ifs
`timescale 1ns / 1ps
`default_nettype none

module ptrq_ctrl (
	input  wire                        clk,
	input  wire                        arst_n,
	ptrq_req_if.sink                   req,
	ptrq_rsp_if.source                 rsp,
	input  ptrq_pkg::rq_entry_t        head,
	input  wire                        gap_any,
	input  wire [ptrq_pkg::SLOT_W-1:0] free_top,
	output ptrq_pkg::rq_cmd_t          rq_cmd,
	output ptrq_pkg::fl_cmd_t          fl_cmd
);
	import ptrq_pkg::*;

	state_t                 state_q, state_d;
	req_code_t              req_q;
	logic [PRIO_BITS-1:0]   prio_q;
	logic [CNT_W-1:0]       running_q, running_d;
	logic [CNT_W-1:0]       count_q, count_d;
	logic [MAX_TASKS-1:0]   has_run_q, has_run_d;
	status_t                status_q, status_d;
	logic [SLOT_W-1:0]      slot_q, slot_d;
	logic                   sw_q, sw_d;
	logic                   fr_q, fr_d;
	logic                   load_out;
	logic                   head_change;
	logic                   out_valid_q;
	status_t                out_status_q;
	logic [SLOT_W-1:0]      out_slot_q;
	logic [CNT_W-1:0]       out_running_q;
	logic                   out_sw_q;
	logic                   out_fr_q;
	logic [CNT_W-1:0]       out_count_q;

	assign head_change = !head.valid || (prio_q > head.prio);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (req.valid) state_d = S_EXEC;
			S_EXEC: begin
				case (req_q)
					REQ_ACTIVATE: begin
						if (count_q == CNT_FULL) state_d = S_DONE;
						else if (head_change) state_d = S_DISP;
						else state_d = S_DONE;
					end
					REQ_TERMINATE: begin
						if (running_q == NONE_SLOT) state_d = S_DONE;
						else state_d = S_PACK;
					end
					REQ_DISPATCH: state_d = S_DISP;
					default: state_d = S_DONE;
				endcase
			end
			S_PACK: begin
				if (!gap_any) state_d = (count_q == '0) ? S_DONE : S_DISP;
			end
			S_DISP: state_d = S_DONE;
			S_DONE: if (!out_valid_q || rsp.ready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs and state updates
	always_comb begin
		rq_cmd    = '{op: RQ_NOP, slot: '0, prio: '0};
		fl_cmd    = '{op: FL_NOP, slot: '0};
		running_d = running_q;
		count_d   = count_q;
		has_run_d = has_run_q;
		status_d  = status_q;
		slot_d    = slot_q;
		sw_d      = sw_q;
		fr_d      = fr_q;
		load_out  = 1'b0;
		req.ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					status_d = ST_OK;
					slot_d   = '0;
					sw_d     = 1'b0;
					fr_d     = 1'b0;
				end
			end
			S_EXEC: begin
				case (req_q)
					REQ_ACTIVATE: begin
						if (count_q == CNT_FULL) begin
							status_d = ST_NO_FREE;
						end else begin
							fl_cmd = '{op: FL_POP, slot: '0};
							rq_cmd = '{op: RQ_INSERT, slot: free_top, prio: prio_q};
							count_d = count_q + CNT_W'(1);
							has_run_d[free_top] = 1'b0;
							slot_d = free_top;
						end
					end
					REQ_TERMINATE: begin
						if (running_q != NONE_SLOT) begin
							rq_cmd = '{op: RQ_REMOVE, slot: running_q[SLOT_W-1:0],
								prio: '0};
							fl_cmd = '{op: FL_PUSH, slot: running_q[SLOT_W-1:0]};
							count_d = count_q - CNT_W'(1);
							running_d = NONE_SLOT;
							if (count_q == CNT_W'(1)) status_d = ST_ALL_DONE;
						end
					end
					default: ;
				endcase
			end
			S_PACK: rq_cmd = '{op: RQ_PACK, slot: '0, prio: '0};
			S_DISP: begin
				if (count_q == '0) begin
					status_d = ST_NO_READY;
				end else begin
					// move the head behind its equal-priority peers
					rq_cmd = '{op: RQ_ROTATE, slot: head.slot, prio: head.prio};
					if (running_q == NONE_SLOT) begin
						running_d = {1'b0, head.slot};
						sw_d = 1'b1;
						fr_d = !has_run_q[head.slot];
						has_run_d[head.slot] = 1'b1;
					end
				end
			end
			S_DONE: load_out = !out_valid_q || rsp.ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			running_q   <= NONE_SLOT;
			count_q     <= '0;
			has_run_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			running_q <= running_d;
			count_q   <= count_d;
			has_run_q <= has_run_d;
			if (load_out) out_valid_q <= 1'b1;
			else if (rsp.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		status_q <= status_d;
		slot_q   <= slot_d;
		sw_q     <= sw_d;
		fr_q     <= fr_d;
		if (state_q == S_IDLE && req.valid) begin
			req_q  <= req_code_t'(req.req_type);
			prio_q <= req.priority_req[PRIO_BITS-1:0];
		end
		if (load_out) begin
			out_status_q  <= status_q;
			out_slot_q    <= slot_q;
			out_running_q <= running_q;
			out_sw_q      <= sw_q;
			out_fr_q      <= fr_q;
			out_count_q   <= count_q;
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.slot         = out_slot_q;
	assign rsp.running_task = out_running_q;
	assign rsp.switched     = out_sw_q;
	assign rsp.first_run    = out_fr_q;
	assign rsp.task_count   = out_count_q;

endmodule

`default_nettype wire

@@ rtl/priority_task_ready_queue.sv @@
// priority_task_ready_queue: top level, rows of ready and free cells plus sequencer
// depends on ptrq_pkg, ptrq_ifs, ptrq_ready_cell, ptrq_free_cell, ptrq_ctrl
//
//  channel  dir  handshake     payload
//  req      in   valid/ready   req_type[1:0], priority_req[7:0]
//  rsp      out  valid/ready   status, slot, running_task, switched, first_run, task_count
//
// one request at a time; after accept the sequencer runs exec then done for an activate
// that keeps the head or finds no free slot, an ignored terminate or an unused code,
// and exec, disp, done when a dispatch runs (dispatch, or activate of a new head);
// terminate runs exec, then pack while a hole is left as the hole walks right, then
// disp and done, or pack then done when it ends the last task
// the result sits in an output register; a new item is taken the cycle after it is
// loaded, and the next result holds the sequencer until that register drains
// reset puts every slot on the free stack in index order, empty ready row,
// nothing running; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none

module priority_task_ready_queue (
	input  wire        clk,
	input  wire        arst_n,
	ptrq_req_if.sink   req,
	ptrq_rsp_if.source rsp
);
	import ptrq_pkg::*;

	rq_cmd_t           rq_cmd;
	fl_cmd_t           fl_cmd;
	rq_entry_t         rq_ent  [MAX_TASKS];
	logic              rq_ge   [MAX_TASKS];
	logic [SLOT_W-1:0] fl_slot [MAX_TASKS];
	logic [MAX_TASKS-2:0] gap;
	logic              gap_any;

	// ready row: sorted by priority, highest at cell 0, ties in arrival order
	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_rq
		rq_entry_t left_ent, right_ent;
		logic      left_ge, right_ge;
		if (i == 0) begin : g_first
			// cell 0 acts as if an always-outranking valid entry sits to its left
			assign left_ent = '{valid: 1'b1, slot: '0, prio: '0};
			assign left_ge  = 1'b1;
		end else begin : g_mid_l
			assign left_ent = rq_ent[i-1];
			assign left_ge  = rq_ge[i-1];
		end
		if (i == MAX_TASKS-1) begin : g_last
			assign right_ent = '{valid: 1'b0, slot: '0, prio: '0};
			assign right_ge  = 1'b0;
		end else begin : g_mid_r
			assign right_ent = rq_ent[i+1];
			assign right_ge  = rq_ge[i+1];
		end
		ptrq_ready_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (rq_cmd),
			.left_ent  (left_ent),
			.left_ge   (left_ge),
			.right_ent (right_ent),
			.right_ge  (right_ge),
			.ent       (rq_ent[i]),
			.ge        (rq_ge[i])
		);
	end

	// a gap is an empty cell with a live entry to its right
	for (genvar i = 0; i < MAX_TASKS-1; i++) begin : g_gap
		assign gap[i] = !rq_ent[i].valid && rq_ent[i+1].valid;
	end
	assign gap_any = |gap;

	// free stack: top at cell 0, pop shifts left, push shifts right
	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_fl
		logic [SLOT_W-1:0] left_slot, right_slot;
		if (i == 0) begin : g_first
			assign left_slot = fl_cmd.slot;
		end else begin : g_mid_l
			assign left_slot = fl_slot[i-1];
		end
		if (i == MAX_TASKS-1) begin : g_last
			assign right_slot = fl_slot[i];
		end else begin : g_mid_r
			assign right_slot = fl_slot[i+1];
		end
		ptrq_free_cell #(
			.INDEX (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (fl_cmd),
			.left_slot  (left_slot),
			.right_slot (right_slot),
			.slot       (fl_slot[i])
		);
	end

	ptrq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.head     (rq_ent[0]),
		.gap_any  (gap_any),
		.free_top (fl_slot[0]),
		.rq_cmd   (rq_cmd),
		.fl_cmd   (fl_cmd)
	);

endmodule

`default_nettype wire

@@ bench/tb_ptrq_ifs.sv @@
// tb_ptrq_ifs: the bench declares no channel interfaces of its own
// the request and result interfaces come from rtl/ptrq_ifs.sv
`timescale 1ns / 1ps

@@ bench/tb_top.sv @@
// tb_top: self-checking bench for the priority task ready queue scheduler
// depends on ptrq_pkg, ptrq_ifs and the priority_task_ready_queue rtl
`timescale 1ns / 1ps

module tb_top;
	import ptrq_pkg::*;

	localparam int NSLOT = MAX_TASKS;
	localparam int LIMIT = 2000000;

	// scheduler task states
	localparam logic [1:0] T_SUSP = 2'd0;
	localparam logic [1:0] T_READY = 2'd1;
	localparam logic [1:0] T_RUN = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] prio;
	} sched_req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [4:0]       slot;
		logic [CNT_W-1:0] running;
		logic             switched;
		logic             first_run;
		logic [CNT_W-1:0] count;
	} sched_rsp_t;

	logic clk = 0;
	logic arst_n = 0;

	ptrq_req_if req_ch ();
	ptrq_rsp_if rsp_ch ();

	priority_task_ready_queue u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch.sink),
		.rsp    (rsp_ch.source)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// scheduler shadow state
	int  nxt [NSLOT];
	int  prv [NSLOT];
	bit  linked [NSLOT];
	int  tprio [NSLOT];
	logic [1:0] tstate [NSLOT];
	bit  ran [NSLOT];
	int  rdy_head, free_head, cur_run, n_active;

	sched_req_t pending_reqs[$];
	sched_rsp_t expected_rsps[$];
	int  send_idle_pct, recv_idle_pct;
	int  hold_cycles;
	bit  failed;
	longint cycle_cnt;

	function automatic void sched_reset();
		for (int i = 0; i < NSLOT; i++) begin
			nxt[i] = (i + 1) % NSLOT;
			prv[i] = (i + NSLOT - 1) % NSLOT;
			linked[i] = 1;
			tprio[i] = 0;
			tstate[i] = T_SUSP;
			ran[i] = 0;
		end
		rdy_head = NSLOT;
		free_head = 0;
		cur_run = NSLOT;
		n_active = 0;
	endfunction

	function automatic void unlink(int t, ref int head);
		int n, p;
		if (t >= NSLOT || !linked[t]) return;
		n = nxt[t];
		p = prv[t];
		if (head == t) head = (n == t) ? NSLOT : n;
		nxt[p] = n;
		prv[n] = p;
		nxt[t] = t;
		prv[t] = t;
		linked[t] = 0;
	endfunction

	function automatic void insert_before(int t, int at, ref int head);
		int p;
		if (t >= NSLOT || linked[t]) return;
		if (at >= NSLOT || head >= NSLOT) begin
			head = t;
			nxt[t] = t;
			prv[t] = t;
			linked[t] = 1;
			return;
		end
		if (at == head) head = t;
		p = prv[at];
		nxt[t] = at;
		prv[t] = p;
		nxt[p] = t;
		prv[at] = t;
		linked[t] = 1;
	endfunction

	function automatic void insert_after(int t, int at);
		int n;
		if (t >= NSLOT || at >= NSLOT || linked[t]) return;
		n = nxt[at];
		nxt[t] = n;
		prv[t] = at;
		prv[n] = t;
		nxt[at] = t;
		linked[t] = 1;
	endfunction

	// keep ready list in descending priority, fifo among equals
	function automatic void place_ready(int t);
		int c;
		if (t >= NSLOT || tstate[t] == T_SUSP) return;
		if (rdy_head >= NSLOT) begin
			insert_before(t, NSLOT, rdy_head);
			return;
		end
		if (n_active <= 1) return;
		unlink(t, rdy_head);
		if (rdy_head >= NSLOT) begin
			insert_before(t, NSLOT, rdy_head);
			return;
		end
		c = rdy_head;
		for (int k = 0; k < NSLOT; k++) begin
			if (tprio[c] < tprio[t]) break;
			c = nxt[c];
			if (c == rdy_head) break;
		end
		if (tprio[t] <= tprio[rdy_head] && c == rdy_head)
			insert_after(t, prv[rdy_head]);
		else
			insert_before(t, c, rdy_head);
	endfunction

	function automatic logic [1:0] pick_next(ref logic sw, ref logic fr);
		int c;
		bit hit;
		hit = 0;
		if (cur_run < NSLOT && tstate[cur_run] == T_RUN) tstate[cur_run] = T_READY;
		if (n_active == 0 || rdy_head >= NSLOT) return ST_NO_READY;
		c = rdy_head;
		for (int k = 0; k < NSLOT; k++) begin
			if (tstate[c] == T_READY) begin
				hit = 1;
				break;
			end
			c = nxt[c];
			if (c == rdy_head) break;
		end
		if (!hit) return ST_NO_READY;
		// non-preemptive: switch only when idle or running task ended
		if (cur_run >= NSLOT || tstate[cur_run] == T_SUSP) begin
			tstate[c] = T_RUN;
			cur_run = c;
			sw = 1;
			fr = !ran[c];
			ran[c] = 1;
		end
		place_ready(c);
		return ST_OK;
	endfunction

	function automatic sched_rsp_t schedule(sched_req_t r);
		sched_rsp_t o;
		int old_head, s;
		logic sw, fr;
		logic [1:0] st;
		sw = 0;
		fr = 0;
		st = ST_OK;
		o.slot = 0;
		case (r.kind)
			REQ_ACTIVATE: begin
				if (free_head >= NSLOT) st = ST_NO_FREE;
				else begin
					old_head = rdy_head;
					s = free_head;
					unlink(s, free_head);
					tprio[s] = r.prio;
					tstate[s] = T_READY;
					ran[s] = 0;
					if (n_active < NSLOT) n_active++;
					place_ready(s);
					if (old_head != rdy_head) st = pick_next(sw, fr);
					o.slot = s[4:0];
				end
			end
			REQ_TERMINATE: begin
				s = cur_run;
				if (s < NSLOT && tstate[s] != T_SUSP) begin
					if (n_active > 0) n_active--;
					tstate[s] = T_SUSP;
					unlink(s, rdy_head);
					insert_before(s, free_head, free_head);
					if (n_active == 0) begin
						cur_run = NSLOT;
						st = ST_ALL_DONE;
					end else st = pick_next(sw, fr);
				end
			end
			REQ_DISPATCH: st = pick_next(sw, fr);
			default: ;
		endcase
		o.status = st;
		o.running = CNT_W'(cur_run);
		o.switched = sw;
		o.first_run = fr;
		o.count = CNT_W'(n_active);
		return o;
	endfunction

	// driver: offers queued items, holds until accepted
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 0;
			req_ch.req_type <= 0;
			req_ch.priority_req <= 0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (req_ch.valid) expected_rsps.push_back(schedule(
				sched_req_t'({req_ch.req_type, req_ch.priority_req})));
			if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				sched_req_t r;
				r = pending_reqs.pop_front();
				req_ch.valid <= 1;
				req_ch.req_type <= r.kind;
				req_ch.priority_req <= r.prio;
			end else req_ch.valid <= 0;
		end
	end

	// monitor: receiver stalls, long hold-off, compare against oldest expectation
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) rsp_ch.ready <= 0;
		else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (expected_rsps.size() == 0) begin
					$error("unexpected result item");
					failed = 1;
				end else begin
					sched_rsp_t e;
					e = expected_rsps.pop_front();
					if (rsp_ch.status !== e.status) begin
						$error("status exp %0d got %0d", e.status, rsp_ch.status);
						failed = 1;
					end
					if (rsp_ch.slot !== e.slot) begin
						$error("slot exp %0d got %0d", e.slot, rsp_ch.slot);
						failed = 1;
					end
					if (rsp_ch.running_task !== e.running) begin
						$error("running_task exp %0d got %0d", e.running,
							rsp_ch.running_task);
						failed = 1;
					end
					if (rsp_ch.switched !== e.switched) begin
						$error("switched exp %0d got %0d", e.switched, rsp_ch.switched);
						failed = 1;
					end
					if (rsp_ch.first_run !== e.first_run) begin
						$error("first_run exp %0d got %0d", e.first_run, rsp_ch.first_run);
						failed = 1;
					end
					if (rsp_ch.task_count !== e.count) begin
						$error("task_count exp %0d got %0d", e.count, rsp_ch.task_count);
						failed = 1;
					end
				end
			end
			if (hold_cycles > 0) begin
				hold_cycles <= hold_cycles - 1;
				rsp_ch.ready <= 0;
			end else rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// cycle limit watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > LIMIT) begin
			$display("priority_task_ready_queue verification failed");
			$finish;
		end
	end

	function automatic sched_req_t mk(logic [1:0] k, logic [7:0] p);
		sched_req_t r;
		r.kind = k;
		r.prio = p;
		return r;
	endfunction

	// random mix weighted toward activates so the list grows deep, with
	// terminates mixed in to drain it and reach the all-done case
	task automatic queue_random(int n);
		int w;
		for (int i = 0; i < n; i++) begin
			w = $urandom_range(99);
			if (w < 45)
				pending_reqs.push_back(mk(REQ_ACTIVATE, ($urandom_range(3) == 0)
					? 8'($urandom) : 8'($urandom_range(3) * 85)));
			else if (w < 70) pending_reqs.push_back(mk(REQ_TERMINATE, 8'($urandom)));
			else if (w < 97) pending_reqs.push_back(mk(REQ_DISPATCH, 8'($urandom)));
			else pending_reqs.push_back(mk(2'd3, 8'($urandom)));
		end
	endtask

	task automatic drain();
		while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_ch.valid)
			@(posedge clk);
	endtask

	initial begin
		failed = 0;
		cycle_cnt = 0;
		hold_cycles = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		sched_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1;

		// directed: empty-list cases, extremes, drain to done, refill
		pending_reqs.push_back(mk(REQ_DISPATCH, 8'h00));
		pending_reqs.push_back(mk(REQ_TERMINATE, 8'h00));
		pending_reqs.push_back(mk(2'd3, 8'hff));
		pending_reqs.push_back(mk(REQ_ACTIVATE, 8'h00));
		pending_reqs.push_back(mk(REQ_ACTIVATE, 8'hff));
		pending_reqs.push_back(mk(REQ_ACTIVATE, 8'hff));
		pending_reqs.push_back(mk(REQ_DISPATCH, 8'h00));
		pending_reqs.push_back(mk(REQ_TERMINATE, 8'h00));
		pending_reqs.push_back(mk(REQ_TERMINATE, 8'h00));
		pending_reqs.push_back(mk(REQ_TERMINATE, 8'h00));
		pending_reqs.push_back(mk(REQ_TERMINATE, 8'h00));
		for (int i = 0; i < 12; i++) pending_reqs.push_back(mk(REQ_ACTIVATE, 8'(i * 23)));
		drain();

		// long receiver hold-off while the sender keeps offering and fills past full
		hold_cycles = 300;
		for (int i = 0; i < 40; i++) pending_reqs.push_back(mk(REQ_ACTIVATE, 8'($urandom)));
		pending_reqs.push_back(mk(REQ_DISPATCH, 8'h55));
		drain();
		for (int i = 0; i < 34; i++) pending_reqs.push_back(mk(REQ_TERMINATE, 8'haa));
		drain();

		send_idle_pct = 25;
		recv_idle_pct = 85;
		queue_random(600);
		drain();
		send_idle_pct = 85;
		recv_idle_pct = 25;
		queue_random(600);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		queue_random(600);
		drain();

		repeat (60) @(posedge clk);
		if (!failed && expected_rsps.size() == 0)
			$display("priority_task_ready_queue verification clean");
		else
			$display("priority_task_ready_queue verification failed");
		$finish;
	end

endmodule
